>>> sv/utf8_charset_presence_map_top_assert.svh
// Assertion macros for the UTF-8 presence map block.
// Used by the port checker; no other dependencies.
`ifndef UTF8_CHARSET_PRESENCE_MAP_TOP_ASSERT_SVH
`define UTF8_CHARSET_PRESENCE_MAP_TOP_ASSERT_SVH

// Same-cycle implication.
`define UCPM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UCPM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication with a delay before the consequent.
`define UCPM_ASSERT_DELAY2(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

>>> sv/ucpm_pkg.sv
// Shared types, constants, microprogram ROM and helpers for the UTF-8 presence map.
// No dependencies.
package ucpm_pkg;

   // Map geometry
   localparam int MAP_WORD_BITS    = 32;
   localparam int CODE_POINT_COUNT = 65536;
   localparam int MAP_DEPTH        = CODE_POINT_COUNT / MAP_WORD_BITS;
   localparam int POINT_W          = $clog2(CODE_POINT_COUNT);
   localparam int CURSOR_W         = POINT_W + 1;
   localparam int WORD_IDX_W       = $clog2(MAP_DEPTH);
   localparam int BIT_IDX_W        = $clog2(MAP_WORD_BITS);

   localparam int SPACE_CODE = 32;
   localparam int SPACE_WORD = SPACE_CODE / MAP_WORD_BITS;
   localparam int SPACE_BIT  = SPACE_CODE % MAP_WORD_BITS;
   localparam logic [MAP_WORD_BITS-1:0] SPACE_MASK = MAP_WORD_BITS'(1) << SPACE_BIT;
   localparam logic [WORD_IDX_W-1:0]    SPACE_WORD_IDX = WORD_IDX_W'(SPACE_WORD);
   localparam logic [WORD_IDX_W-1:0]    LAST_WORD_IDX  = WORD_IDX_W'(MAP_DEPTH - 1);
   localparam logic [CURSOR_W-1:0]      CURSOR_START   = CURSOR_W'(SPACE_CODE);

   // Byte classes
   localparam logic [7:0] SPACE_BYTE = 8'(SPACE_CODE);
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] LEAD2_MIN  = 8'hC0;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD_MAX   = 8'hEF;
   localparam logic [7:0] BOM_BYTE0  = 8'hEF;
   localparam logic [7:0] BOM_BYTE1  = 8'hBB;
   localparam logic [7:0] BOM_BYTE2  = 8'hBF;

   typedef enum logic [1:0] {
      OP_FEED    = 2'd0,
      OP_FETCH   = 2'd1,
      OP_RESTART = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERROR = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BOM_START,
      BOM_SEEN_EF,
      BOM_SEEN_BB,
      BOM_PAST
   } bom_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } ucpm_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [POINT_W-1:0] code_point;
   } ucpm_rsp_type;

   // Microprogram steps
   typedef enum logic [3:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_FEED,
      STEP_MARK,
      STEP_FETCH,
      STEP_SCAN_CHECK,
      STEP_SCAN_READ,
      STEP_SCAN_EVAL,
      STEP_END,
      STEP_STATUS,
      STEP_RESTART
   } step_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_BRANCH,       // cond ? target : next step
      SEQ_BRANCH_IDLE,  // cond ? target : idle
      SEQ_DISPATCH
   } seq_type;

   typedef enum logic [2:0] {
      COND_CLR_MORE,
      COND_MARK,
      COND_ERR,
      COND_END,
      COND_MISS
   } cond_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_READ_MARK,
      MEM_WRITE_MARK,
      MEM_READ_SCAN
   } mem_op_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_STATUS,
      RSP_HIT,
      RSP_END,
      RSP_OK
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_CLEAR_ADV,
      ACT_FEED,
      ACT_SCAN,
      ACT_RESTART
   } act_type;

   typedef struct packed {
      seq_type      seq;
      cond_type     cond;
      step_type     target;
      logic         wait_start;
      mem_op_type   mem_op;
      rsp_kind_type rsp;
      act_type      act;
   } ucpm_ctrl_type;

   typedef struct packed {
      logic clr_more;
      logic mark;
      logic err;
      logic at_end;
      logic miss;
   } ucpm_flags_type;

   typedef struct packed {
      logic               valid;
      logic [POINT_W-1:0] point;
   } ucpm_mark_type;

   typedef struct packed {
      logic               clr_more;
      logic               at_end;
      logic               hit;
      logic [POINT_W-1:0] point;
   } ucpm_scan_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] idx;
   } ucpm_ffs_type;

   function automatic ucpm_ctrl_type ctrl_word(
      input seq_type seq, input cond_type cond, input step_type target,
      input logic wait_start, input mem_op_type mem_op, input rsp_kind_type rsp,
      input act_type act);
      ucpm_ctrl_type c;
      c.seq        = seq;
      c.cond       = cond;
      c.target     = target;
      c.wait_start = wait_start;
      c.mem_op     = mem_op;
      c.rsp        = rsp;
      c.act        = act;
      return c;
   endfunction

   // Control store: one word per step
   function automatic ucpm_ctrl_type ucpm_rom(input step_type step);
      ucpm_ctrl_type c;
      unique case (step)
         STEP_CLEAR:      c = ctrl_word(SEQ_BRANCH_IDLE, COND_CLR_MORE, STEP_CLEAR, 1'b0,
                                        MEM_CLEAR, RSP_NONE, ACT_CLEAR_ADV);
         STEP_IDLE:       c = ctrl_word(SEQ_DISPATCH, COND_ERR, STEP_IDLE, 1'b1,
                                        MEM_NONE, RSP_NONE, ACT_NONE);
         STEP_FEED:       c = ctrl_word(SEQ_BRANCH_IDLE, COND_MARK, STEP_MARK, 1'b0,
                                        MEM_READ_MARK, RSP_STATUS, ACT_FEED);
         STEP_MARK:       c = ctrl_word(SEQ_JUMP, COND_ERR, STEP_IDLE, 1'b0,
                                        MEM_WRITE_MARK, RSP_NONE, ACT_NONE);
         STEP_FETCH:      c = ctrl_word(SEQ_BRANCH, COND_ERR, STEP_STATUS, 1'b0,
                                        MEM_NONE, RSP_NONE, ACT_NONE);
         STEP_SCAN_CHECK: c = ctrl_word(SEQ_BRANCH, COND_END, STEP_END, 1'b0,
                                        MEM_NONE, RSP_NONE, ACT_NONE);
         STEP_SCAN_READ:  c = ctrl_word(SEQ_NEXT, COND_ERR, STEP_IDLE, 1'b0,
                                        MEM_READ_SCAN, RSP_NONE, ACT_NONE);
         STEP_SCAN_EVAL:  c = ctrl_word(SEQ_BRANCH_IDLE, COND_MISS, STEP_SCAN_CHECK, 1'b0,
                                        MEM_NONE, RSP_HIT, ACT_SCAN);
         STEP_END:        c = ctrl_word(SEQ_JUMP, COND_ERR, STEP_IDLE, 1'b0,
                                        MEM_NONE, RSP_END, ACT_NONE);
         STEP_STATUS:     c = ctrl_word(SEQ_JUMP, COND_ERR, STEP_IDLE, 1'b0,
                                        MEM_NONE, RSP_STATUS, ACT_NONE);
         STEP_RESTART:    c = ctrl_word(SEQ_JUMP, COND_ERR, STEP_CLEAR, 1'b0,
                                        MEM_NONE, RSP_OK, ACT_RESTART);
         default:         c = ctrl_word(SEQ_JUMP, COND_ERR, STEP_IDLE, 1'b0,
                                        MEM_NONE, RSP_NONE, ACT_NONE);
      endcase
      return c;
   endfunction

   // Lowest set bit of a map word
   function automatic ucpm_ffs_type ucpm_first_set(input logic [MAP_WORD_BITS-1:0] v);
      ucpm_ffs_type r;
      r = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.idx   = BIT_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> sv/ucpm_seq.sv
// Microprogram sequencer: step counter, control store lookup, branches and dispatch.
// Depends on ucpm_pkg.
module ucpm_seq
   import ucpm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     operation,
   input  ucpm_flags_type flags,
   output ucpm_ctrl_type  ctrl
);

   step_type upc_ff, upc_in;
   step_type step_next;
   logic     cond_true;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      ctrl      = ucpm_rom(upc_ff);
      step_next = step_type'(upc_ff + 4'd1);

      unique case (ctrl.cond)
         COND_CLR_MORE: cond_true = flags.clr_more;
         COND_MARK:     cond_true = flags.mark;
         COND_ERR:      cond_true = flags.err;
         COND_END:      cond_true = flags.at_end;
         COND_MISS:     cond_true = flags.miss;
         default:       cond_true = 1'b0;
      endcase

      unique case (ctrl.seq)
         SEQ_NEXT:        upc_in = step_next;
         SEQ_JUMP:        upc_in = ctrl.target;
         SEQ_BRANCH:      upc_in = cond_true ? ctrl.target : step_next;
         SEQ_BRANCH_IDLE: upc_in = cond_true ? ctrl.target : STEP_IDLE;
         SEQ_DISPATCH: begin
            if (start) begin
               unique case (operation)
                  OP_FEED:    upc_in = STEP_FEED;
                  OP_FETCH:   upc_in = STEP_FETCH;
                  OP_RESTART: upc_in = STEP_RESTART;
                  default:    upc_in = STEP_STATUS;
               endcase
            end else begin
               upc_in = STEP_IDLE;
            end
         end
         default:         upc_in = STEP_IDLE;
      endcase
   end

endmodule

>>> sv/ucpm_decoder.sv
// UTF-8 byte decoder: pending count, gathered bits, byte order mark tracking, sticky error.
// Depends on ucpm_pkg.
module ucpm_decoder
   import ucpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  act_type       act,
   input  logic [7:0]    data_byte,
   output ucpm_mark_type mark,
   output logic          err_ff,
   output logic          err_in
);

   logic [1:0]         pending_ff, pending_in;
   logic [POINT_W-1:0] partial_ff, partial_in;
   bom_type            bom_ff, bom_in;
   logic               skip_mark;
   logic [POINT_W-1:0] done_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         partial_ff <= '0;
         bom_ff     <= BOM_START;
         err_ff     <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         bom_ff     <= bom_in;
         err_ff     <= err_in;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      bom_in     = bom_ff;
      err_in     = err_ff;
      mark       = '0;
      skip_mark  = 1'b0;
      done_point = partial_ff | {10'b0, data_byte[5:0]};

      if (act == ACT_RESTART) begin
         pending_in = '0;
         partial_in = '0;
         bom_in     = BOM_START;
         err_in     = 1'b0;
      end else if (act == ACT_FEED && !err_ff) begin
         unique case (bom_ff)
            BOM_START:   bom_in = (data_byte == BOM_BYTE0) ? BOM_SEEN_EF : BOM_PAST;
            BOM_SEEN_EF: bom_in = (data_byte == BOM_BYTE1) ? BOM_SEEN_BB : BOM_PAST;
            BOM_SEEN_BB: begin
               skip_mark = (data_byte == BOM_BYTE2);
               bom_in    = BOM_PAST;
            end
            default:     bom_in = BOM_PAST;
         endcase

         priority if (pending_ff == 2'd2) begin
            partial_in = partial_ff | {4'b0, data_byte[5:0], 6'b0};
            pending_in = 2'd1;
         end else if (pending_ff == 2'd1) begin
            pending_in = 2'd0;
            partial_in = '0;
            mark.valid = !skip_mark;
            mark.point = done_point;
         end else if (data_byte == 8'h00 || data_byte > LEAD_MAX) begin
            err_in = 1'b1;
         end else if (data_byte >= LEAD3_MIN) begin
            partial_in = {data_byte[3:0], 12'b0};
            pending_in = 2'd2;
         end else if (data_byte >= LEAD2_MIN) begin
            partial_in = {5'b0, data_byte[4:0], 6'b0};
            pending_in = 2'd1;
         end else if (data_byte >= CONT_MIN) begin
            err_in = 1'b1;
         end else if (data_byte >= SPACE_BYTE) begin
            mark.valid = 1'b1;
            mark.point = {8'b0, data_byte};
         end else begin
            // control bytes 01-1F: drop
         end
      end
   end

endmodule

>>> sv/ucpm_map.sv
// Presence map memory with clearing pointer, mark read-modify-write and scan cursor.
// Depends on ucpm_pkg.
module ucpm_map
   import ucpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ucpm_ctrl_type ctrl,
   input  ucpm_mark_type mark,
   output ucpm_scan_type scan
);

   logic [MAP_WORD_BITS-1:0] map_mem [MAP_DEPTH];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;

   logic [WORD_IDX_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CURSOR_W-1:0]   cursor_ff, cursor_in;
   logic [POINT_W-1:0]    mark_pt_ff, mark_pt_in;

   logic                     wr_en, rd_en;
   logic [WORD_IDX_W-1:0]    wr_addr, rd_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;
   logic [WORD_IDX_W-1:0]    cur_word;
   logic [BIT_IDX_W-1:0]     cur_bit;
   logic [MAP_WORD_BITS-1:0] masked;
   ucpm_ffs_type             ffs;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         cursor_ff  <= CURSOR_START;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         cursor_ff  <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      mark_pt_ff <= mark_pt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_comb begin
      cur_word = cursor_ff[POINT_W-1:BIT_IDX_W];
      cur_bit  = cursor_ff[BIT_IDX_W-1:0];
      // ignore points below the cursor within its word
      masked   = rd_data_ff & ({MAP_WORD_BITS{1'b1}} << cur_bit);
      ffs      = ucpm_first_set(masked);

      scan.clr_more = (clr_ptr_ff != LAST_WORD_IDX);
      scan.at_end   = cursor_ff[POINT_W];
      scan.hit      = ffs.found;
      scan.point    = {cur_word, ffs.idx};

      clr_ptr_in = clr_ptr_ff;
      cursor_in  = cursor_ff;
      mark_pt_in = mark_pt_ff;
      unique case (ctrl.act)
         ACT_RESTART: begin
            clr_ptr_in = '0;
            cursor_in  = CURSOR_START;
         end
         ACT_CLEAR_ADV: clr_ptr_in = clr_ptr_ff + WORD_IDX_W'(1);
         ACT_SCAN: begin
            if (ffs.found) begin
               cursor_in = {1'b0, scan.point} + CURSOR_W'(1);
            end else begin
               // advance to the first point of the next word
               cursor_in = {({1'b0, cur_word} + (WORD_IDX_W + 1)'(1)),
                            {BIT_IDX_W{1'b0}}};
            end
         end
         default: ;
      endcase

      wr_en   = 1'b0;
      rd_en   = 1'b0;
      wr_addr = clr_ptr_ff;
      rd_addr = cur_word;
      wr_data = '0;
      unique case (ctrl.mem_op)
         MEM_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_ff;
            wr_data = (clr_ptr_ff == SPACE_WORD_IDX) ? SPACE_MASK : '0;
         end
         MEM_READ_MARK: begin
            rd_en      = 1'b1;
            rd_addr    = mark.point[POINT_W-1:BIT_IDX_W];
            mark_pt_in = mark.point;
         end
         MEM_WRITE_MARK: begin
            wr_en   = 1'b1;
            wr_addr = mark_pt_ff[POINT_W-1:BIT_IDX_W];
            wr_data = rd_data_ff | (MAP_WORD_BITS'(1) << mark_pt_ff[BIT_IDX_W-1:0]);
         end
         MEM_READ_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = cur_word;
         end
         default: ;
      endcase
   end

endmodule

>>> sv/utf8_charset_presence_map_top.sv
// UTF-8 code point presence map: top level with request latch and result register.
// Depends on ucpm_pkg, ucpm_seq, ucpm_decoder and ucpm_map.
//
// Usage: drive req_payload and raise start; the request transfers at a rising edge with
// start high and busy low. Each request gives exactly one result, shown on rsp_payload
// for one cycle with rsp_strobe high; the receiver cannot stall, so capture it then.
// Operations: feed a byte, fetch the next marked code point (ascending from space),
// restart (clear map and decoder).
// Steps from transfer to strobe and to the next accepted request:
//   feed: the feed step reads the map word and answers with the status; a mark step
//     writes the word back when the byte marks a point (read-modify-write of one map word).
//   fetch: after the fetch step, check, read and evaluate steps for each map word examined;
//     a hit answers with the code point, and a cursor already past the map answers with
//     the end status. A fetch after a stream error answers with the error status.
//   restart / unused operation: restart answers from the restart step, an unused operation
//     from the status step; restart then clears the map.
// Clearing pass: after reset and after every restart the sequencer writes all 2048 map
// words, one per cycle, with busy high; after a restart the restart step comes first.
// The sequencer is microcoded: one control word per step from a small ROM.
module utf8_charset_presence_map_top
   import ucpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ucpm_req_type req_payload,
   output logic         rsp_strobe,
   output ucpm_rsp_type rsp_payload
);

   ucpm_ctrl_type  ctrl;
   ucpm_flags_type flags;
   ucpm_mark_type  mark;
   ucpm_scan_type  scan;
   ucpm_req_type   req_ff;
   ucpm_rsp_type   rsp_ff, rsp_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic           err_ff, err_in;
   logic           accept;

   assign busy   = !ctrl.wait_start;
   assign accept = start && !busy;

   ucpm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_payload.operation),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   ucpm_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .act       (ctrl.act),
      .data_byte (req_ff.data_byte),
      .mark      (mark),
      .err_ff    (err_ff),
      .err_in    (err_in)
   );

   ucpm_map u_map (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .mark  (mark),
      .scan  (scan)
   );

   always_comb begin
      flags.clr_more = scan.clr_more;
      flags.mark     = mark.valid;
      flags.err      = err_ff;
      flags.at_end   = scan.at_end;
      flags.miss     = !scan.hit;
   end

   // hold the request for the steps after the transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      unique case (ctrl.rsp)
         RSP_STATUS: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = err_in ? ST_ERROR : ST_OK;
         end
         RSP_HIT: begin
            rsp_strobe_in     = scan.hit;
            rsp_in.status     = ST_OK;
            rsp_in.code_point = scan.point;
         end
         RSP_END: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = ST_END;
         end
         RSP_OK: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/ucpm_checker.sv
// Port-level checker for the UTF-8 presence map top level, bound to it below.
// Depends on ucpm_pkg and utf8_charset_presence_map_top_assert.svh.
`include "utf8_charset_presence_map_top_assert.svh"

module ucpm_checker
   import ucpm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input ucpm_req_type req_payload,
   input logic         rsp_strobe,
   input ucpm_rsp_type rsp_payload
);

   // the block is busy in the cycle after every transfer
   `UCPM_ASSERT_NEXT(a_busy_after_transfer, clock, reset, start && !busy, busy, "not busy after transfer")

   `UCPM_ASSERT_NEXT(a_no_early_result, clock, reset, start && !busy, !rsp_strobe, "result one cycle after transfer")

   `UCPM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "strobe in two cycles in a row")

   `UCPM_ASSERT_IMPLY(a_point_zero_on_status, clock, reset, rsp_strobe && rsp_payload.status != ST_OK, rsp_payload.code_point == '0, "code point set with non-ok status")

   `UCPM_ASSERT_DELAY2(a_restart_result, clock, reset, start && !busy && req_payload.operation == OP_RESTART, rsp_strobe && rsp_payload.status == ST_OK, "restart result missing")

endmodule

bind utf8_charset_presence_map_top ucpm_checker u_checker (.*);
